// ===== design/cqi_pkg.sv =====
// cqi_pkg: shared types, character codes and operation tables for the
// cigar reference-to-query interval block. No dependencies.
`default_nettype none

package cqi_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_9  = 8'h39;
   localparam logic [7:0] CH_M  = 8'h4d;
   localparam logic [7:0] CH_I  = 8'h49;
   localparam logic [7:0] CH_D  = 8'h44;
   localparam logic [7:0] CH_N  = 8'h4e;
   localparam logic [7:0] CH_S  = 8'h53;
   localparam logic [7:0] CH_H  = 8'h48;
   localparam logic [7:0] CH_P  = 8'h50;
   localparam logic [7:0] CH_EQ = 8'h3d;
   localparam logic [7:0] CH_X  = 8'h58;

   localparam logic [1:0] REG_QUERY_START = 2'd0;
   localparam logic [1:0] REG_QUERY_STOP  = 2'd1;
   localparam logic [1:0] REG_REF_OFFSET  = 2'd2;

   typedef enum logic [3:0] {
      OP_M, OP_I, OP_D, OP_N, OP_S, OP_H, OP_P, OP_EQ, OP_X
   } op_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BAD       = 2'd2
   } status_type;

   typedef struct packed {
      op_type op;
      logic   apply;
      logic   bad;
      logic   pend;
      logic   last;
   } cqi_ctl_type;

   function automatic logic op_valid(logic [7:0] c);
      logic v;
      unique case (c)
         CH_M, CH_I, CH_D, CH_N, CH_S, CH_H, CH_P, CH_EQ, CH_X: v = 1'b1;
         default: v = 1'b0;
      endcase
      return v;
   endfunction

   function automatic op_type op_decode(logic [7:0] c);
      op_type o;
      unique case (c)
         CH_I:    o = OP_I;
         CH_D:    o = OP_D;
         CH_N:    o = OP_N;
         CH_S:    o = OP_S;
         CH_H:    o = OP_H;
         CH_P:    o = OP_P;
         CH_EQ:   o = OP_EQ;
         CH_X:    o = OP_X;
         default: o = OP_M;
      endcase
      return o;
   endfunction

   function automatic logic uses_ref(op_type o);
      logic v;
      unique case (o)
         OP_M, OP_D, OP_N, OP_EQ, OP_X: v = 1'b1;
         default: v = 1'b0;
      endcase
      return v;
   endfunction

   function automatic logic uses_read(op_type o);
      logic v;
      unique case (o)
         OP_M, OP_I, OP_S, OP_EQ, OP_X: v = 1'b1;
         default: v = 1'b0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== design/cqi_front.sv =====
// cqi_front: takes cigar characters, builds operation lengths, classifies
// them and queues operations, bad and last characters. Depends on cqi_pkg.
`default_nettype none

module cqi_front #(
   parameter int OP_LEN_BITS = 28
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_cigar_char,
   input  logic                     req_last,
   input  logic                     q_full,
   output logic                     push,
   output cqi_pkg::cqi_ctl_type     push_ctl,
   output logic [OP_LEN_BITS-1:0]   push_size
);
   import cqi_pkg::*;

   logic [OP_LEN_BITS-1:0] len_ff, len_in;
   logic                   hd_ff, hd_in;
   logic                   acc, is_digit, is_op, ovf, bad;
   logic [3:0]             digit;
   logic [OP_LEN_BITS+3:0] grown;

   assign req_ready = ~q_full;
   assign acc       = req_valid & req_ready;

   always_comb begin
      is_digit = (req_cigar_char >= CH_0) && (req_cigar_char <= CH_9);
      is_op    = op_valid(req_cigar_char);
      digit    = 4'(req_cigar_char - CH_0);
      grown    = {1'b0, len_ff, 3'b000} + {3'b000, len_ff, 1'b0} + (OP_LEN_BITS+4)'(digit);
      ovf      = grown[OP_LEN_BITS+3:OP_LEN_BITS] != 4'd0;
      bad      = (~is_digit & ~is_op) | (is_digit & ovf);

      push_ctl.op    = op_decode(req_cigar_char);
      push_ctl.apply = is_op & (len_ff != '0);
      push_ctl.bad   = bad;
      push_ctl.pend  = is_digit ? (ovf ? hd_ff : 1'b1) : (is_op ? 1'b0 : hd_ff);
      push_ctl.last  = req_last;
      push_size      = len_ff;
      push           = acc & (req_last | bad | push_ctl.apply);

      len_in = len_ff;
      hd_in  = hd_ff;
      if (acc) begin
         if (req_last) begin
            len_in = '0;
            hd_in  = 1'b0;
         end else if (is_digit && !ovf) begin
            len_in = grown[OP_LEN_BITS-1:0];
            hd_in  = 1'b1;
         end else if (is_op) begin
            len_in = '0;
            hd_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         hd_ff  <= 1'b0;
      end else begin
         len_ff <= len_in;
         hd_ff  <= hd_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/cqi_queue.sv =====
// cqi_queue: small fifo of classified entries between front and back.
// Depends on cqi_pkg for its depth.
`default_nettype none

module cqi_queue #(
   parameter int DATA_BITS = 36
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] head_data,
   output logic                 head_valid
);
   import cqi_pkg::*;

   localparam int QA = $clog2(QUEUE_DEPTH);

   logic [DATA_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [QA-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QA:0]          count_ff, count_in;

   assign full       = count_ff == (QA+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QA'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QA'(1) : rd_ptr_ff;
      count_in  = count_ff + (QA+1)'(push) - (QA+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/cqi_back.sv =====
// cqi_back: applies operations to reference and query coordinates, tracks
// where the interval ends fall and registers one result per string.
// Depends on cqi_pkg.
`default_nettype none

module cqi_back #(
   parameter int OP_LEN_BITS = 28,
   parameter int COORD_BITS  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  cqi_pkg::cqi_ctl_type     head_ctl,
   input  logic [OP_LEN_BITS-1:0]   head_size,
   output logic                     head_pop,
   input  logic [30:0]              query_start,
   input  logic [30:0]              query_stop,
   input  logic [30:0]              ref_offset,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [31:0]       rsp_sub_start,
   output logic signed [31:0]       rsp_sub_stop
);
   import cqi_pkg::*;

   localparam int RW = (COORD_BITS > 31) ? COORD_BITS : 31;
   localparam logic [RW:0]   COORD_LIM = (RW+1)'(1) << COORD_BITS;
   localparam logic [RW-1:0] COORD_MAX = RW'(COORD_LIM - (RW+1)'(1));
   localparam logic [RW:0]   POS_LIM   = (RW+1)'(64'h8000_0000);

   function automatic logic [30:0] sub_pos(logic [30:0] q, logic [RW-1:0] rs,
                                           logic [RW-1:0] ss);
      logic [RW:0] v;
      v = ((RW+1)'(q) - {1'b0, rs}) + {1'b0, ss};
      return (v >= POS_LIM) ? 31'h7fff_ffff : v[30:0];
   endfunction

   // stage 1 state
   logic          fresh_ff, fresh_in, err_ff, err_in, stop_ff, stop_in;
   logic          seen_ff, seen_in;
   logic [RW-1:0] ref_pos_ff, ref_pos_in, read_pos_ff, read_pos_in;
   // stage 2 registers
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_last_ff, s2_err_ff, s2_hit_s_ff, s2_hit_p_ff;
   logic [RW-1:0] s2_rs_ff, s2_ss_ff;
   logic          fs_valid_ff, fs_valid_in, fp_valid_ff, fp_valid_in;
   logic [30:0]   fs_pos_ff, fs_pos_in, fp_pos_ff, fp_pos_in;
   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_start_ff, rsp_start_in, rsp_stop_ff, rsp_stop_in;

   logic          s2_stall, s2_fire, active, take, chk;
   logic          hit_s, hit_p, stop_hit, err_now, stop_now, err_final;
   logic [30:0]   start_ref;
   logic [RW-1:0] rs, ss, re, nread, qs, qp;
   logic [RW:0]   ref_sum, read_sum;
   logic          fs_v_new, fp_v_new;
   logic [30:0]   fs_p_new, fp_p_new;

   // stage 1: coordinate update and interval checks
   always_comb begin
      s2_stall  = s2_valid_ff & s2_last_ff & rsp_valid_ff & ~rsp_ready;
      head_pop  = head_valid & ~s2_stall;
      start_ref = (ref_offset == '0) ? '0 : ref_offset - 31'd1;
      rs        = fresh_ff ? RW'(start_ref) : ref_pos_ff;
      ss        = fresh_ff ? '0 : read_pos_ff;
      qs        = RW'(query_start);
      qp        = RW'(query_stop);
      active    = ~err_ff & ~stop_ff;
      take      = active & head_ctl.apply;
      ref_sum   = {1'b0, rs} + (RW+1)'(head_size);
      read_sum  = {1'b0, ss} + (RW+1)'(head_size);
      re        = rs;
      nread     = ss;
      if (take && uses_ref(head_ctl.op)) begin
         re = (ref_sum >= COORD_LIM) ? COORD_MAX : ref_sum[RW-1:0];
      end
      if (take && uses_read(head_ctl.op)) begin
         nread = (read_sum >= COORD_LIM) ? COORD_MAX : read_sum[RW-1:0];
      end
      chk       = take & (head_ctl.op != OP_S);
      hit_s     = chk & (rs <= qs) & (re >= qs);
      hit_p     = chk & (rs <= qp) & (re >= qp);
      stop_hit  = chk & (seen_ff | hit_p) & (re < qs);
      err_now   = err_ff | (active & head_ctl.bad);
      stop_now  = stop_ff | stop_hit;
      err_final = err_now | (~stop_now & head_ctl.pend);

      fresh_in    = fresh_ff;
      err_in      = err_ff;
      stop_in     = stop_ff;
      seen_in     = seen_ff;
      ref_pos_in  = ref_pos_ff;
      read_pos_in = read_pos_ff;
      if (head_pop) begin
         if (head_ctl.last) begin
            fresh_in = 1'b1;
            err_in   = 1'b0;
            stop_in  = 1'b0;
            seen_in  = 1'b0;
         end else begin
            fresh_in    = 1'b0;
            err_in      = err_now;
            stop_in     = stop_now;
            seen_in     = seen_ff | hit_p;
            ref_pos_in  = re;
            read_pos_in = nread;
         end
      end
      s2_valid_in = s2_stall ? s2_valid_ff : head_pop;
   end

   // stage 2: substring positions and result
   always_comb begin
      s2_fire  = s2_valid_ff & ~s2_stall;
      fs_v_new = fs_valid_ff | s2_hit_s_ff;
      fp_v_new = fp_valid_ff | s2_hit_p_ff;
      fs_p_new = s2_hit_s_ff ? sub_pos(query_start, s2_rs_ff, s2_ss_ff) : fs_pos_ff;
      fp_p_new = s2_hit_p_ff ? sub_pos(query_stop, s2_rs_ff, s2_ss_ff) : fp_pos_ff;

      fs_valid_in = fs_valid_ff;
      fp_valid_in = fp_valid_ff;
      fs_pos_in   = fs_pos_ff;
      fp_pos_in   = fp_pos_ff;
      if (s2_fire) begin
         fs_valid_in = fs_v_new & ~s2_last_ff;
         fp_valid_in = fp_v_new & ~s2_last_ff;
         fs_pos_in   = fs_p_new;
         fp_pos_in   = fp_p_new;
      end

      rsp_valid_in  = (s2_fire & s2_last_ff) | (rsp_valid_ff & ~rsp_ready);
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_stop_in   = rsp_stop_ff;
      if (s2_fire && s2_last_ff) begin
         if (s2_err_ff) begin
            rsp_status_in = ST_BAD;
            rsp_start_in  = '1;
            rsp_stop_in   = '1;
         end else begin
            rsp_status_in = (fs_v_new && fp_v_new) ? ST_FOUND : ST_NOT_FOUND;
            rsp_start_in  = fs_v_new ? {1'b0, fs_p_new} : '1;
            rsp_stop_in   = fp_v_new ? {1'b0, fp_p_new} : '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= 1'b1;
         err_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fs_valid_ff  <= 1'b0;
         fp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fresh_ff     <= fresh_in;
         err_ff       <= err_in;
         stop_ff      <= stop_in;
         seen_ff      <= seen_in;
         s2_valid_ff  <= s2_valid_in;
         fs_valid_ff  <= fs_valid_in;
         fp_valid_ff  <= fp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_pos_ff    <= ref_pos_in;
      read_pos_ff   <= read_pos_in;
      fs_pos_ff     <= fs_pos_in;
      fp_pos_ff     <= fp_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_stop_ff   <= rsp_stop_in;
      if (!s2_stall) begin
         s2_last_ff  <= head_ctl.last;
         s2_err_ff   <= err_final;
         s2_hit_s_ff <= hit_s;
         s2_hit_p_ff <= hit_p;
         s2_rs_ff    <= rs;
         s2_ss_ff    <= ss;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_sub_start = rsp_start_ff;
   assign rsp_sub_stop  = rsp_stop_ff;

endmodule

`default_nettype wire

// ===== design/cigar_ref_to_query_interval.sv =====
// cigar_ref_to_query_interval: top level with register port, front,
// entry queue and back. Depends on cqi_pkg, cqi_front, cqi_queue, cqi_back.
//
//   channel   handshake               payload
//   req       req_valid / req_ready   req_cigar_char, req_last
//   rsp       rsp_valid / rsp_ready   rsp_status, rsp_sub_start, rsp_sub_stop
//   csr       psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// one character per cycle while the queue is not full. after the last character
// is accepted, its entry goes through the queue, the coordinate stage and then
// the position stage to the output register; queued entries ahead delay it.
// the four-entry queue lets the front keep taking characters while a result
// waits in the output register. reset clears control state only; registers
// come out of reset with query_start 0, query_stop 0, ref_offset 1.
`default_nettype none

module cigar_ref_to_query_interval #(
   parameter int OP_LEN_BITS = 28,
   parameter int COORD_BITS  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_cigar_char,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_sub_start,
   output logic signed [31:0] rsp_sub_stop,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import cqi_pkg::*;

   localparam int QW = $bits(cqi_ctl_type) + OP_LEN_BITS;

   logic [30:0]            qs_ff, qs_in, qp_ff, qp_in, ro_ff, ro_in;
   logic                   wr;
   logic                   q_full, push, head_valid, head_pop;
   cqi_ctl_type            push_ctl, head_ctl;
   logic [OP_LEN_BITS-1:0] push_size, head_size;
   logic [QW-1:0]          head_data;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite & pready;

   always_comb begin
      qs_in = qs_ff;
      qp_in = qp_ff;
      ro_in = ro_ff;
      if (wr) begin
         unique case (paddr[3:2])
            REG_QUERY_START: qs_in = pwdata[30:0];
            REG_QUERY_STOP:  qp_in = pwdata[30:0];
            REG_REF_OFFSET:  ro_in = pwdata[30:0];
            default: ;
         endcase
      end
      unique case (paddr[3:2])
         REG_QUERY_START: prdata = {1'b0, qs_ff};
         REG_QUERY_STOP:  prdata = {1'b0, qp_ff};
         REG_REF_OFFSET:  prdata = {1'b0, ro_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qs_ff <= '0;
         qp_ff <= '0;
         ro_ff <= 31'd1;
      end else begin
         qs_ff <= qs_in;
         qp_ff <= qp_in;
         ro_ff <= ro_in;
      end
   end

   cqi_front #(.OP_LEN_BITS(OP_LEN_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cigar_char (req_cigar_char),
      .req_last       (req_last),
      .q_full         (q_full),
      .push           (push),
      .push_ctl       (push_ctl),
      .push_size      (push_size)
   );

   cqi_queue #(.DATA_BITS(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_ctl, push_size}),
      .full       (q_full),
      .pop        (head_pop),
      .head_data  (head_data),
      .head_valid (head_valid)
   );

   assign head_ctl  = cqi_ctl_type'(head_data[QW-1:OP_LEN_BITS]);
   assign head_size = head_data[OP_LEN_BITS-1:0];

   cqi_back #(.OP_LEN_BITS(OP_LEN_BITS), .COORD_BITS(COORD_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_ctl      (head_ctl),
      .head_size     (head_size),
      .head_pop      (head_pop),
      .query_start   (qs_ff),
      .query_stop    (qp_ff),
      .ref_offset    (ro_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_sub_start (rsp_sub_start),
      .rsp_sub_stop  (rsp_sub_stop)
   );

endmodule

`default_nettype wire
